[hw/rtl/fdts_pkg.sv]
// Package for the fan duty top-N saturation block: widths, reset values,
// register indexes and shared types. Depends on nothing.
package fdts_pkg;

   localparam int MAX_FANS     = 8;
   localparam int NUM_FANS_DEF = 8;
   localparam int DUTY_W_DEF   = 16;
   localparam int LIMIT_W      = 13;
   localparam int COUNT_W      = 4;
   localparam int OUT_W        = 13;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 13;

   localparam logic [LIMIT_W-1:0] LIMIT_RST = 13'd4096;
   localparam logic [COUNT_W-1:0] COUNT_RST = 4'd8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DUTY_LIMIT = 1'b0,
      CSR_SAT_COUNT  = 1'b1
   } csr_index_type;

   typedef logic [LIMIT_W-1:0] limit_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [OUT_W-1:0]   duty_out_type;

endpackage

[hw/rtl/fdts_core.sv]
// Combinational saturation core: counts duties above the limit, ranks the fans
// and selects either top-N or clipped duties. Depends on fdts_pkg.
module fdts_core #(
   parameter int NUM_FANS = fdts_pkg::NUM_FANS_DEF,
   parameter int DUTY_W   = fdts_pkg::DUTY_W_DEF
) (
   input  logic [DUTY_W-1:0]      duty [NUM_FANS],
   input  fdts_pkg::limit_type    limit,
   input  fdts_pkg::count_type    sat_count,
   output fdts_pkg::duty_out_type duty_out [NUM_FANS],
   output logic                   top_n
);
   import fdts_pkg::*;

   localparam int CMP_W = (DUTY_W > LIMIT_W) ? DUTY_W : LIMIT_W;

   logic [CMP_W-1:0] dext [NUM_FANS];
   logic [CMP_W-1:0] lim_ext;
   logic             above [NUM_FANS];
   count_type        over;
   count_type        rank [NUM_FANS];

   assign lim_ext = CMP_W'(limit);

   always_comb begin
      over = '0;
      for (int i = 0; i < NUM_FANS; i++) begin
         dext[i]  = CMP_W'(duty[i]);
         above[i] = dext[i] > lim_ext;
         if (above[i]) begin
            over = over + COUNT_W'(1);
         end
      end
   end

   assign top_n = over >= sat_count;

   always_comb begin
      for (int i = 0; i < NUM_FANS; i++) begin
         rank[i] = '0;
         for (int j = 0; j < NUM_FANS; j++) begin
            if ((dext[j] > dext[i]) || ((dext[j] == dext[i]) && (j < i))) begin
               rank[i] = rank[i] + COUNT_W'(1);
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_FANS; i++) begin
         if (top_n) begin
            duty_out[i] = (rank[i] < sat_count) ? OUT_W'(limit) : '0;
         end else if (above[i]) begin
            duty_out[i] = OUT_W'(limit);
         end else begin
            duty_out[i] = dext[i][OUT_W-1:0];
         end
      end
   end

endmodule

[hw/rtl/fan_duty_top_n_saturation_core.sv]
// Top level of the fan duty top-N saturation block: request register,
// saturation core, response register and configuration registers.
// Depends on fdts_pkg and fdts_core.
// A request accepted at a clock edge passes the request register and then the
// response register, which shows it with rsp_valid high until rsp_ready takes it.
// One request is accepted per cycle unless rsp_ready holds the response register.
// Synchronous reset empties both registers, sets duty_limit to 4096 and
// saturate_count to 8.
module fan_duty_top_n_saturation_core #(
   parameter int NUM_FANS = fdts_pkg::NUM_FANS_DEF,
   parameter int DUTY_W   = fdts_pkg::DUTY_W_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [DUTY_W-1:0]               req_duty_in_0,
   input  logic [DUTY_W-1:0]               req_duty_in_1,
   input  logic [DUTY_W-1:0]               req_duty_in_2,
   input  logic [DUTY_W-1:0]               req_duty_in_3,
   input  logic [DUTY_W-1:0]               req_duty_in_4,
   input  logic [DUTY_W-1:0]               req_duty_in_5,
   input  logic [DUTY_W-1:0]               req_duty_in_6,
   input  logic [DUTY_W-1:0]               req_duty_in_7,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output fdts_pkg::duty_out_type          rsp_duty_out_0,
   output fdts_pkg::duty_out_type          rsp_duty_out_1,
   output fdts_pkg::duty_out_type          rsp_duty_out_2,
   output fdts_pkg::duty_out_type          rsp_duty_out_3,
   output fdts_pkg::duty_out_type          rsp_duty_out_4,
   output fdts_pkg::duty_out_type          rsp_duty_out_5,
   output fdts_pkg::duty_out_type          rsp_duty_out_6,
   output fdts_pkg::duty_out_type          rsp_duty_out_7,
   output logic                            rsp_top_n_mode,
   input  logic                            csr_write_en,
   input  logic [fdts_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fdts_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fdts_pkg::*;

   logic [DUTY_W-1:0] req_all [MAX_FANS];
   logic [DUTY_W-1:0] duty_ff [NUM_FANS];
   logic              req_valid_ff;
   logic              advance;

   duty_out_type      core_out [NUM_FANS];
   logic              core_top_n;
   duty_out_type      rsp_duty_in [MAX_FANS];
   duty_out_type      rsp_duty_ff [MAX_FANS];
   logic              rsp_top_n_ff;
   logic              rsp_valid_ff;

   limit_type         limit_ff;
   count_type         count_ff;
   csr_index_type     csr_sel;

   assign req_all[0] = req_duty_in_0;
   assign req_all[1] = req_duty_in_1;
   assign req_all[2] = req_duty_in_2;
   assign req_all[3] = req_duty_in_3;
   assign req_all[4] = req_duty_in_4;
   assign req_all[5] = req_duty_in_5;
   assign req_all[6] = req_duty_in_6;
   assign req_all[7] = req_duty_in_7;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         for (int i = 0; i < NUM_FANS; i++) begin
            duty_ff[i] <= req_all[i];
         end
      end
   end

   fdts_core #(
      .NUM_FANS (NUM_FANS),
      .DUTY_W   (DUTY_W)
   ) u_core (
      .duty      (duty_ff),
      .limit     (limit_ff),
      .sat_count (count_ff),
      .duty_out  (core_out),
      .top_n     (core_top_n)
   );

   always_comb begin
      for (int i = 0; i < MAX_FANS; i++) begin
         rsp_duty_in[i] = '0;
      end
      for (int i = 0; i < NUM_FANS; i++) begin
         rsp_duty_in[i] = core_out[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_valid_ff) begin
         rsp_duty_ff  <= rsp_duty_in;
         rsp_top_n_ff <= core_top_n;
      end
   end

   assign csr_sel = csr_index_type'(csr_index);

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RST;
         count_ff <= COUNT_RST;
      end else if (csr_write_en) begin
         unique case (csr_sel)
            CSR_DUTY_LIMIT: begin
               limit_ff <= csr_wdata[LIMIT_W-1:0];
            end
            CSR_SAT_COUNT: begin
               count_ff <= csr_wdata[COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_top_n_mode = rsp_top_n_ff;
   assign rsp_duty_out_0 = rsp_duty_ff[0];
   assign rsp_duty_out_1 = rsp_duty_ff[1];
   assign rsp_duty_out_2 = rsp_duty_ff[2];
   assign rsp_duty_out_3 = rsp_duty_ff[3];
   assign rsp_duty_out_4 = rsp_duty_ff[4];
   assign rsp_duty_out_5 = rsp_duty_ff[5];
   assign rsp_duty_out_6 = rsp_duty_ff[6];
   assign rsp_duty_out_7 = rsp_duty_ff[7];

   // Every response field stays at or below the limit, and all are zero
   // when the top-N rule runs with a count of zero.
   logic rsp_below_limit;
   logic rsp_all_zero;

   always_comb begin
      rsp_below_limit = 1'b1;
      rsp_all_zero    = 1'b1;
      for (int i = 0; i < MAX_FANS; i++) begin
         if (rsp_duty_ff[i] > OUT_W'(limit_ff)) begin
            rsp_below_limit = 1'b0;
         end
         if (rsp_duty_ff[i] != '0) begin
            rsp_all_zero = 1'b0;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> req_valid_ff)
      else $error("accepted request did not reach the request register");

   assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(duty_ff[0]))
      else $error("stalled request register lost its contents");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_below_limit)
      else $error("response duty above the limit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_top_n_ff && (count_ff == '0) |-> rsp_all_zero)
      else $error("top-N response with zero count is not all zero");

endmodule

[tb/fan_duty_top_n_saturation_core_tb.sv]
// Self-checking testbench for fan_duty_top_n_saturation_core: directed and random
// duty sets under many duty_limit / saturate_count settings, checked against
// a behavioral predictor. Depends on fdts_pkg and the block's RTL.
`timescale 1ns / 100ps

module fan_duty_top_n_saturation_core_tb;

   import fdts_pkg::*;

   localparam int DUTY_W        = DUTY_W_DEF;
   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 150;
   localparam int DRAIN_CYCLES  = 10;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int REPORT_LIMIT  = 20;

   typedef logic [MAX_FANS-1:0][DUTY_W-1:0] duty_set_type;

   typedef struct packed {
      logic                       top_n;
      duty_out_type [MAX_FANS-1:0] duty;
   } fan_result_type;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_SPARSE,
      RX_LONG_STALL
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_valid = 1'b0;
   wire                              req_ready;
   duty_set_type                     req_duty = '0;
   wire                              rsp_valid;
   logic                             rsp_ready = 1'b0;
   wire  [MAX_FANS-1:0][OUT_W-1:0]   rsp_duty;
   wire                              rsp_top_n_mode;
   logic                             csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]             csr_index = CSR_DUTY_LIMIT;
   logic [CSR_DATA_W-1:0]            csr_wdata = '0;

   limit_type        limit_cfg = LIMIT_RST;
   count_type        count_cfg = COUNT_RST;
   fan_result_type   expected_duties[$];

   int  cycle_count = 0;
   int  fail_count = 0;
   int  requests_sent = 0;
   int  responses_checked = 0;
   int  top_n_responses = 0;
   int  settings_applied = 0;
   int  burst_left = 0;
   bit  sender_gaps = 1'b1;

   rx_mode_type rx_mode = RX_ALWAYS;
   int          rx_run = 0;

   fan_duty_top_n_saturation_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_duty_in_0  (req_duty[0]),
      .req_duty_in_1  (req_duty[1]),
      .req_duty_in_2  (req_duty[2]),
      .req_duty_in_3  (req_duty[3]),
      .req_duty_in_4  (req_duty[4]),
      .req_duty_in_5  (req_duty[5]),
      .req_duty_in_6  (req_duty[6]),
      .req_duty_in_7  (req_duty[7]),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_duty_out_0 (rsp_duty[0]),
      .rsp_duty_out_1 (rsp_duty[1]),
      .rsp_duty_out_2 (rsp_duty[2]),
      .rsp_duty_out_3 (rsp_duty[3]),
      .rsp_duty_out_4 (rsp_duty[4]),
      .rsp_duty_out_5 (rsp_duty[5]),
      .rsp_duty_out_6 (rsp_duty[6]),
      .rsp_duty_out_7 (rsp_duty[7]),
      .rsp_top_n_mode (rsp_top_n_mode),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("fan_duty_top_n_saturation_core: mismatch");
      $finish;
   end

   function automatic fan_result_type limit_fan_duties(input duty_set_type duties);
      fan_result_type result;
      int             over;
      int             rank;
      int             i;
      int             j;
      over = 0;
      for (i = 0; i < MAX_FANS; i++) begin
         if (duties[i] > limit_cfg) over++;
      end
      result.top_n = (over >= count_cfg);
      for (i = 0; i < MAX_FANS; i++) begin
         if (result.top_n) begin
            rank = 0;
            for (j = 0; j < MAX_FANS; j++) begin
               if (duties[j] > duties[i] || (duties[j] == duties[i] && j < i)) rank++;
            end
            result.duty[i] = (rank < count_cfg) ? limit_cfg : '0;
         end else begin
            result.duty[i] = (duties[i] > limit_cfg) ? limit_cfg : duties[i][OUT_W-1:0];
         end
      end
      return result;
   endfunction

   function automatic duty_set_type uniform_duties(input int value);
      duty_set_type ds;
      int           f;
      for (f = 0; f < MAX_FANS; f++) ds[f] = DUTY_W'(value);
      return ds;
   endfunction

   function automatic duty_set_type random_duty_set(input int over_pct);
      duty_set_type ds;
      int           f;
      int           pick;
      for (f = 0; f < MAX_FANS; f++) begin
         pick = $urandom_range(0, 99);
         if (f > 0 && pick < 12) begin
            ds[f] = ds[$urandom_range(0, f - 1)];
         end else if (pick >= 94) begin
            ds[f] = DUTY_W'($urandom_range(0, 65535));
         end else if ($urandom_range(0, 99) < over_pct) begin
            case ($urandom_range(0, 3))
               0: ds[f] = DUTY_W'(limit_cfg + 1);
               1: ds[f] = '1;
               2: ds[f] = DUTY_W'($urandom_range(limit_cfg + 1, 65535));
               default: ds[f] = DUTY_W'($urandom_range(limit_cfg + 1, limit_cfg + 64));
            endcase
         end else begin
            case ($urandom_range(0, 3))
               0: ds[f] = '0;
               1: ds[f] = DUTY_W'(limit_cfg);
               2: ds[f] = DUTY_W'($urandom_range(0, limit_cfg));
               default: ds[f] = (limit_cfg == 0) ? '0 : DUTY_W'(limit_cfg - 1);
            endcase
         end
      end
      return ds;
   endfunction

   // Each call starts and ends at a rising edge; valid is only lowered when a
   // gap follows, so it never gets two assignments in one step.
   task automatic send_request(input duty_set_type duties);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_gaps ? $urandom_range(0, 10) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_duty  <= duties;
      do @(negedge clock); while (!req_ready);
      expected_duties.insert(expected_duties.size(), limit_fan_duties(duties));
      requests_sent++;
      @(posedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (expected_duties.size() != 0);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_DUTY_LIMIT: limit_cfg = data[LIMIT_W-1:0];
         CSR_SAT_COUNT:  count_cfg = data[COUNT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic apply_setting(input int limit, input int count);
      logic [CSR_DATA_W-1:0] count_word;
      pause_until_drained();
      count_word = CSR_DATA_W'(count);
      // Bits above the count field are ignored by the block.
      if ($urandom_range(0, 1)) begin
         count_word[CSR_DATA_W-1:COUNT_W] = (CSR_DATA_W-COUNT_W)'($urandom_range(0, 511));
      end
      write_register(CSR_DUTY_LIMIT, CSR_DATA_W'(limit));
      write_register(CSR_SAT_COUNT, count_word);
      settings_applied++;
   endtask

   task automatic test_reset_values();
      duty_set_type ds;
      int           f;
      send_request(uniform_duties(65535));
      send_request(uniform_duties(4096));
      send_request(uniform_duties(4097));
      ds = uniform_duties(65535);
      ds[5] = '0;
      send_request(ds);
      for (f = 0; f < MAX_FANS; f++) ds[f] = DUTY_W'(1 << (2 * f));
      send_request(ds);
      for (f = 0; f < MAX_FANS; f++) ds[f] = DUTY_W'(1 << (2 * f + 1));
      send_request(ds);
   endtask

   task automatic test_directed_cases();
      duty_set_type ds;
      int           f;
      apply_setting(4096, 0);
      send_request(uniform_duties(65535));
      send_request(uniform_duties(0));
      apply_setting(1000, 3);
      send_request(uniform_duties(2000));
      for (f = 0; f < MAX_FANS; f++) ds[f] = DUTY_W'(1000 + 1000 * f);
      send_request(ds);
      for (f = 0; f < MAX_FANS; f++) ds[f] = DUTY_W'((f % 2) ? 7000 : 5000);
      send_request(ds);
      ds = uniform_duties(900);
      ds[2] = DUTY_W'(3000);
      ds[6] = DUTY_W'(1001);
      send_request(ds);
      apply_setting(4096, 15);
      send_request(uniform_duties(65535));
      apply_setting(4096, 9);
      send_request(uniform_duties(65535));
      apply_setting(0, 8);
      send_request(uniform_duties(1));
      apply_setting(0, 9);
      send_request(uniform_duties(65535));
      apply_setting(8191, 1);
      ds = uniform_duties(8191);
      ds[4] = '1;
      send_request(ds);
      send_request(uniform_duties(8191));
      apply_setting(1, 8);
      send_request(uniform_duties(2));
   endtask

   task automatic test_random_settings();
      int phase;
      int item;
      int limit;
      int count;
      int over_pct;
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:  begin limit = 4096; count = 8;  end
            1:  begin limit = 1;    count = 0;  end
            2:  begin limit = 8191; count = 15; end
            3:  begin limit = 0;    count = 1;  end
            4:  begin limit = 4096; count = 4;  end
            5:  begin limit = 2048; count = 3;  end
            6:  begin limit = 100;  count = 7;  end
            7:  begin limit = 8191; count = 8;  end
            8:  begin limit = 4095; count = 2;  end
            default: begin
               limit = $urandom_range(1, 4096);
               count = $urandom_range(0, 9);
            end
         endcase
         apply_setting(limit, count);
         sender_gaps = (phase % 3 != 1);
         for (item = 0; item < PHASE_ITEMS; item++) begin
            if (item == PHASE_ITEMS / 2 && phase % 2 == 0) pause_until_drained();
            case ($urandom_range(0, 4))
               0: over_pct = 0;
               1: over_pct = 25;
               2: over_pct = 50;
               3: over_pct = 85;
               default: over_pct = 100;
            endcase
            send_request(random_duty_set(over_pct));
         end
      end
   endtask

   always @(posedge clock) begin
      if (rx_run == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_run  = $urandom_range(4, 40);
      end
      rx_run--;
      case (rx_mode)
         RX_ALWAYS:     rsp_ready <= 1'b1;
         RX_RANDOM:     rsp_ready <= 1'($urandom_range(0, 1));
         RX_SPARSE:     rsp_ready <= (rx_run % 4 == 0);
         RX_LONG_STALL: rsp_ready <= (rx_run < 3);
         default:       rsp_ready <= 1'b1;
      endcase
   end

   always @(negedge clock) begin : check_response
      fan_result_type          want;
      fan_result_type          got;
      logic [MAX_FANS:0]       bad_fields;
      int                      f;
      if (!reset && rsp_valid && rsp_ready) begin
         got.duty  = rsp_duty;
         got.top_n = rsp_top_n_mode;
         if (expected_duties.size() == 0) begin
            fail_count++;
            $display("%0t ns: response with no request outstanding, actual mode %0d",
                     $time, got.top_n);
         end else begin
            want = expected_duties.pop_front();
            responses_checked++;
            if (want.top_n) top_n_responses++;
            for (f = 0; f < MAX_FANS; f++) bad_fields[f] = (got.duty[f] !== want.duty[f]);
            bad_fields[MAX_FANS] = (got.top_n !== want.top_n);
            if (bad_fields != '0) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $display("%0t ns: wrong response %0d, fields (mode, fan 7..0) %b",
                           $time, responses_checked, bad_fields);
                  $display("   expected mode %0d duties %0d %0d %0d %0d %0d %0d %0d %0d",
                           want.top_n, want.duty[0], want.duty[1], want.duty[2],
                           want.duty[3], want.duty[4], want.duty[5], want.duty[6],
                           want.duty[7]);
                  $display("   actual   mode %0d duties %0d %0d %0d %0d %0d %0d %0d %0d",
                           got.top_n, got.duty[0], got.duty[1], got.duty[2],
                           got.duty[3], got.duty[4], got.duty[5], got.duty[6],
                           got.duty[7]);
               end
            end
         end
      end
   end

   initial begin : run_tests
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed_cases();
      test_random_settings();
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests over %0d register settings; %0d responses checked,",
               requests_sent, settings_applied, responses_checked);
      $display("%0d of them in top-N mode, %0d failures.", top_n_responses, fail_count);
      if (fail_count == 0 && expected_duties.size() == 0) begin
         $display("fan_duty_top_n_saturation_core: match");
      end else begin
         $display("fan_duty_top_n_saturation_core: mismatch");
      end
      $finish;
   end

endmodule

[filelist.f]
hw/rtl/fdts_pkg.sv
hw/rtl/fdts_core.sv
hw/rtl/fan_duty_top_n_saturation_core.sv
tb/fan_duty_top_n_saturation_core_tb.sv
